@@ rtl/core/sorted_longest_decreasing_chain_macros.svh @@
// ---------------------------------------------------------------------------
// sorted_longest_decreasing_chain_macros.svh
// Assertion macros for the decreasing chain block.
// ---------------------------------------------------------------------------
`ifndef SORTED_LONGEST_DECREASING_CHAIN_MACROS_SVH
`define SORTED_LONGEST_DECREASING_CHAIN_MACROS_SVH

`ifndef SYNTH
`define SLDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sldc check failed");
`define SLDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sldc check failed");
`else
`define SLDC_ASSERT_NOW(label, ante, cons)
`define SLDC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/sldc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sldc_pkg
// Shared constants and types of the decreasing chain block.
// ---------------------------------------------------------------------------
package sldc_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int WEIGHT_W        = 16;
  localparam int SCORE_W         = 16;
  localparam int ID_W            = 7;
  localparam int LEN_W           = 7;
  localparam int KEY_W           = WEIGHT_W + SCORE_W;

  typedef enum logic [11:0] {
    ST_LOAD       = 12'b000000000001,
    ST_SORT_FETCH = 12'b000000000010,
    ST_SORT_GRAB  = 12'b000000000100,
    ST_SORT_SWEEP = 12'b000000001000,
    ST_DP_FETCH   = 12'b000000010000,
    ST_DP_GRAB    = 12'b000000100000,
    ST_DP_SWEEP   = 12'b000001000000,
    ST_BT_RD      = 12'b000010000000,
    ST_BT_WR      = 12'b000100000000,
    ST_EM_RD      = 12'b001000000000,
    ST_EM_LOAD    = 12'b010000000000,
    ST_EM_WAIT    = 12'b100000000000
  } state_t;

endpackage

@@ rtl/core/sldc_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sldc_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module sldc_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/sorted_longest_decreasing_chain.sv @@
`timescale 1ns / 1ps
`include "sorted_longest_decreasing_chain_macros.svh"
// ---------------------------------------------------------------------------
// sorted_longest_decreasing_chain
// Longest strictly falling score chain over records sorted by weight.
// ---------------------------------------------------------------------------
// Records load one per cycle; ids are arrival position plus one. The transfer
// flagged final_record starts the computation over n stored records and the
// input stalls until the last chain member has been taken. Sorting ranks each
// record by a sweep over the key RAM; the chain search sweeps the record RAM
// once per record; the backtrace reads the record RAM and writes each chain
// member's id into the key RAM, and the emission reads them back one chain
// member at a time, waiting while out_stall is high. Each RAM has a single
// read port that returns one entry per cycle.
module sorted_longest_decreasing_chain #(
  parameter int MAX_RECORDS = sldc_pkg::MAX_RECORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sldc_pkg::WEIGHT_W-1:0] in_weight,
  input  logic [sldc_pkg::SCORE_W-1:0]  in_score,
  input  logic                       in_final_record,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sldc_pkg::ID_W-1:0]  out_record_id,
  output logic [sldc_pkg::LEN_W-1:0] out_chain_length,
  output logic                       out_last_of_chain
);

  import sldc_pkg::*;

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int DW = SCORE_W + ID_W + CW + AW;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, n_r, n_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0] rank_r, rank_nxt, len_r, len_nxt, best_r, best_nxt, k_r, k_nxt;
  logic [AW-1:0] pj_r, pj_nxt, link_r, link_nxt, end_r, end_nxt, pos_r, pos_nxt;
  logic          pv_r, pv_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [SCORE_W-1:0] si_r, si_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic          ov_r, ov_nxt, last_r, last_nxt;
  logic [ID_W-1:0]  orid_r, orid_nxt;
  logic [LEN_W-1:0] olen_r, olen_nxt;

  logic             k_we, d_we;
  logic [AW-1:0]    k_waddr, k_raddr, d_waddr, d_raddr;
  logic [KEY_W-1:0] k_wdata, k_rdata;
  logic [DW-1:0]    d_wdata, d_rdata;

  logic [SCORE_W-1:0] dj_score;
  logic [ID_W-1:0]    dj_id;
  logic [CW-1:0]      dj_len;
  logic [AW-1:0]      dj_link;
  logic [CW-1:0]      lim;
  logic               in_xfer;

  assign {dj_score, dj_id, dj_len, dj_link} = d_rdata;
  assign in_xfer = in_valid && !in_stall;
  assign lim     = state_r == ST_SORT_SWEEP ? n_r : i_r;

  sldc_ram #(.W(KEY_W), .DEPTH(MAX_RECORDS)) u_key_ram (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata)
  );

  sldc_ram #(.W(DW), .DEPTH(MAX_RECORDS)) u_rec_ram (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;   n_nxt = n_r;       i_nxt = i_r;       j_nxt = j_r;
    rank_nxt = rank_r; len_nxt = len_r;   best_nxt = best_r; k_nxt = k_r;
    pj_nxt = pj_r;     link_nxt = link_r; end_nxt = end_r;   pos_nxt = pos_r;
    pv_nxt = 1'b0;     key_nxt = key_r;   si_nxt = si_r;     id_nxt = id_r;
    ov_nxt = ov_r;     last_nxt = last_r; orid_nxt = orid_r; olen_nxt = olen_r;
    k_we = 1'b0; k_waddr = cnt_r[AW-1:0]; k_wdata = {in_weight, in_score};
    k_raddr = '0;
    d_we = 1'b0; d_waddr = '0; d_wdata = {si_r, id_r, len_r, link_r};
    d_raddr = '0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (cnt_r < CW'(MAX_RECORDS)) begin
            k_we    = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_final_record) begin
            n_nxt     = cnt_r < CW'(MAX_RECORDS) ? cnt_r + 1'b1 : cnt_r;
            cnt_nxt   = '0;
            i_nxt     = '0;
            state_nxt = ST_SORT_FETCH;
          end
        end
      end
      ST_SORT_FETCH: begin
        k_raddr   = i_r[AW-1:0];
        state_nxt = ST_SORT_GRAB;
      end
      ST_SORT_GRAB: begin
        key_nxt   = k_rdata;
        rank_nxt  = '0;
        j_nxt     = '0;
        state_nxt = ST_SORT_SWEEP;
      end
      ST_SORT_SWEEP: begin
        if (j_r < lim) begin
          k_raddr = j_r[AW-1:0];
          j_nxt   = j_r + 1'b1;
          pv_nxt  = 1'b1;
          pj_nxt  = j_r[AW-1:0];
        end
        if (pv_r && (k_rdata < key_r || (k_rdata == key_r && pj_r < i_r[AW-1:0]))) begin
          rank_nxt = rank_r + 1'b1;
        end
        if (j_r >= lim && !pv_r) begin
          d_we    = 1'b1;
          d_waddr = rank_r[AW-1:0];
          d_wdata = {key_r[SCORE_W-1:0], ID_W'(i_r + 1'b1), len_r, link_r};
          i_nxt   = i_r + 1'b1;
          if (i_r + 1'b1 == n_r) begin
            i_nxt     = '0;
            best_nxt  = CW'(1);
            end_nxt   = '0;
            state_nxt = ST_DP_FETCH;
          end else begin
            state_nxt = ST_SORT_FETCH;
          end
        end
      end
      ST_DP_FETCH: begin
        d_raddr   = i_r[AW-1:0];
        state_nxt = ST_DP_GRAB;
      end
      ST_DP_GRAB: begin
        si_nxt    = dj_score;
        id_nxt    = dj_id;
        len_nxt   = CW'(1);
        link_nxt  = i_r[AW-1:0];
        j_nxt     = '0;
        state_nxt = ST_DP_SWEEP;
      end
      ST_DP_SWEEP: begin
        if (j_r < lim) begin
          d_raddr = j_r[AW-1:0];
          j_nxt   = j_r + 1'b1;
          pv_nxt  = 1'b1;
          pj_nxt  = j_r[AW-1:0];
        end
        if (pv_r && si_r < dj_score && len_r <= dj_len) begin
          len_nxt  = dj_len + 1'b1;
          link_nxt = pj_r;
        end
        if (j_r >= lim && !pv_r) begin
          d_we    = 1'b1;
          d_waddr = i_r[AW-1:0];
          if (len_r > best_r) begin
            best_nxt = len_r;
            end_nxt  = i_r[AW-1:0];
          end
          i_nxt = i_r + 1'b1;
          if (i_r + 1'b1 == n_r) begin
            k_nxt     = (len_r > best_r ? len_r : best_r) - 1'b1;
            pos_nxt   = len_r > best_r ? i_r[AW-1:0] : end_r;
            state_nxt = ST_BT_RD;
          end else begin
            state_nxt = ST_DP_FETCH;
          end
        end
      end
      ST_BT_RD: begin
        d_raddr   = pos_r;
        state_nxt = ST_BT_WR;
      end
      ST_BT_WR: begin
        k_we    = 1'b1;
        k_waddr = k_r[AW-1:0];
        k_wdata = KEY_W'(dj_id);
        pos_nxt = dj_link;
        if (k_r == '0) begin
          state_nxt = ST_EM_RD;
        end else begin
          k_nxt     = k_r - 1'b1;
          state_nxt = ST_BT_RD;
        end
      end
      ST_EM_RD: begin
        k_raddr   = k_r[AW-1:0];
        state_nxt = ST_EM_LOAD;
      end
      ST_EM_LOAD: begin
        orid_nxt  = k_rdata[ID_W-1:0];
        olen_nxt  = LEN_W'(best_r);
        last_nxt  = k_r + 1'b1 == best_r;
        ov_nxt    = 1'b1;
        state_nxt = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          if (last_r) begin
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_EM_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;       i_r <= i_nxt;       j_r <= j_nxt;       rank_r <= rank_nxt;
    len_r <= len_nxt;   best_r <= best_nxt; k_r <= k_nxt;       pj_r <= pj_nxt;
    link_r <= link_nxt; end_r <= end_nxt;   pos_r <= pos_nxt;   key_r <= key_nxt;
    si_r <= si_nxt;     id_r <= id_nxt;     last_r <= last_nxt; orid_r <= orid_nxt;
    olen_r <= olen_nxt;
  end

  assign in_stall          = state_r != ST_LOAD;
  assign out_valid         = ov_r;
  assign out_record_id     = orid_r;
  assign out_chain_length  = olen_r;
  assign out_last_of_chain = last_r;

  `SLDC_ASSERT_NOW(a_no_load_while_out, out_valid, in_stall)
  `SLDC_ASSERT_NOW(a_id_nonzero, out_valid, out_record_id != '0 && out_chain_length != '0)
  `SLDC_ASSERT_NEXT(a_last_ends, out_valid && !out_stall && out_last_of_chain, !in_stall)
  `SLDC_ASSERT_NOW(a_bt_in_range, state_r == ST_BT_WR, k_r < best_r)

endmodule
